>>> hdl/mep_pkg.sv
// Shared types and codes for the maximum-value expression parenthesization block.
`timescale 1ns / 1ps
package mep_pkg;

  // Operator codes carried with each digit.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_BAD = 2'd3;

  // Error codes returned with the result.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OP    = 2'd1;
  localparam logic [1:0] ERR_COUNT = 2'd2;

  typedef struct packed {
    logic [3:0] digit;
    logic [1:0] opcode;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [63:0] max_value;
    logic [1:0]         error;
  } out_t;

endpackage

>>> hdl/mep_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module mep_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and a registered read that returns the old entry on a clash.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/max_expression_parenthesization.sv
// Top level: interval min/max table engine for the best parenthesization.
//
// The expression arrives on the in channel (valid/ready), one transaction per
// digit with the operator that follows it; last marks the final digit. Each
// digit is written to the diagonal of the min and max tables as it is taken,
// so non-final transactions are taken back to back while the output
// register is free or being emptied. On the final digit the tables are
// filled diagonal by diagonal. Every split point reads each table twice
// through its single read port, left operand then right, then takes four
// operand pairs, each through a registered multiply stage and an accumulate
// stage. Each interval adds a write state, and S_DONE then loads the
// result into the output register.
// An error or a single digit gives its result straight from the idle state.
// The result sits in an output register on the out channel; a stalled
// receiver holds the block in its final state, and the in channel is taken
// again once the output register is free or being emptied.
// Reset clears the digit count, error state and control; table contents are
// left as they are, since every entry read is written first.
`timescale 1ns / 1ps
module max_expression_parenthesization #(
  parameter int MAX_DIGITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mep_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mep_pkg::out_t out_data
);
  import mep_pkg::*;

  localparam int IW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int DEPTH = MAX_DIGITS * MAX_DIGITS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDL  = 8'b0000_0010,
    S_RDR  = 8'b0000_0100,
    S_CAP  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CW-1:0] dcount;
  logic [CW-1:0] n_reg;
  logic [1:0]    err;
  logic [1:0]    op_store [MAX_DIGITS];

  logic [IW-1:0] span;
  logic [IW-1:0] lo;
  logic [IW-1:0] k;
  logic [IW-1:0] hi;
  logic [1:0]    cnt_t;

  logic [63:0] lmin, lmax, rmin, rmax;
  logic [63:0] min_rd, max_rd;
  logic [63:0] opa, opb;
  logic [63:0] p_lo;
  logic [31:0] p_c1, p_c2;
  logic [63:0] addsub_q;
  logic [1:0]  op_q;
  logic [63:0] val;
  logic signed [63:0] best_min, best_max;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_min, wr_max;
  logic [AW-1:0] rd_addr;

  logic          accept;
  logic          full;
  logic [IW-1:0] pos;
  logic [1:0]    err_next;
  logic          out_free;

  // Handshake and load decode.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (dcount == CW'(MAX_DIGITS));
  assign pos      = dcount[IW-1:0];
  assign hi       = IW'(lo + span);

  // First error wins: count overflow first, then a bad operator.
  always_comb begin
    err_next = err;
    if (err == ERR_NONE) begin
      if (full) begin
        err_next = ERR_COUNT;
      end else if (!in_data.last && (in_data.opcode == OP_BAD)) begin
        err_next = ERR_OP;
      end
    end
  end

  // Table ports: loading writes the diagonal, the fill writes finished intervals.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(int'(pos) * MAX_DIGITS + int'(pos));
    wr_min  = {60'd0, in_data.digit};
    wr_max  = {60'd0, in_data.digit};
    if (accept && !full) begin
      wr_en = 1'b1;
    end else if (state == S_WR) begin
      wr_en   = 1'b1;
      wr_addr = AW'(int'(lo) * MAX_DIGITS + int'(hi));
      wr_min  = best_min;
      wr_max  = best_max;
    end
    if (state == S_RDL) begin
      rd_addr = AW'(int'(lo) * MAX_DIGITS + int'(k));
    end else begin
      rd_addr = AW'(int'(IW'(k + 1'b1)) * MAX_DIGITS + int'(hi));
    end
  end

  mep_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_min_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_min),
    .rd_addr (rd_addr),
    .rd_data (min_rd)
  );

  mep_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_max_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_max),
    .rd_addr (rd_addr),
    .rd_data (max_rd)
  );

  // Operand pair for the current combination: max/max, max/min, min/max, min/min.
  assign opa = cnt_t[1] ? lmin : lmax;
  assign opb = cnt_t[0] ? rmin : rmax;

  // Wrapped 64-bit product rebuilt from registered partial products.
  assign val = (op_q == OP_MUL) ? (p_lo + {32'(p_c1 + p_c2), 32'd0}) : addsub_q;

  // Operator store: written while loading, read at the split point.
  always_ff @(posedge clk) begin
    if (accept && !full && !in_data.last) begin
      op_store[pos] <= in_data.opcode;
    end
  end

  // Datapath registers; the running extremes restart at the first split of each
  // interval, so the last interval's maximum survives into the result.
  always_ff @(posedge clk) begin
    if (state == S_RDR) begin
      lmin <= min_rd;
      lmax <= max_rd;
    end
    if (state == S_CAP) begin
      rmin <= min_rd;
      rmax <= max_rd;
    end
    if (state == S_MUL) begin
      p_lo     <= 64'(opa[31:0]) * 64'(opb[31:0]);
      p_c1     <= opa[63:32] * opb[31:0];
      p_c2     <= opa[31:0] * opb[63:32];
      addsub_q <= (op_store[k] == OP_SUB) ? (opa - opb) : (opa + opb);
      op_q     <= op_store[k];
    end
    if (state == S_ACC) begin
      if ($signed(val) < best_min) begin
        best_min <= $signed(val);
      end
      if ($signed(val) > best_max) begin
        best_max <= $signed(val);
      end
    end
    if ((state == S_RDL) && (k == lo)) begin
      best_min <= 64'sh7FFF_FFFF_FFFF_FFFF;
      best_max <= 64'sh8000_0000_0000_0000;
    end
  end

  // Sequencer over diagonals, intervals and split points.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dcount    <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
      n_reg     <= '0;
      span      <= '0;
      lo        <= '0;
      k         <= '0;
      cnt_t     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!in_data.last) begin
              err <= err_next;
              if (!full) begin
                dcount <= CW'(dcount + 1'b1);
              end
            end else begin
              dcount <= '0;
              err    <= ERR_NONE;
              if (err_next != ERR_NONE) begin
                out_valid          <= 1'b1;
                out_data.max_value <= '0;
                out_data.error     <= err_next;
              end else if (dcount == '0) begin
                out_valid          <= 1'b1;
                out_data.max_value <= {60'd0, in_data.digit};
                out_data.error     <= ERR_NONE;
              end else begin
                n_reg <= CW'(dcount + 1'b1);
                span  <= IW'(1);
                lo    <= '0;
                k     <= '0;
                state <= S_RDL;
              end
            end
          end
        end
        S_RDL: state <= S_RDR;
        S_RDR: state <= S_CAP;
        S_CAP: begin
          cnt_t <= '0;
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          cnt_t <= cnt_t + 1'b1;
          if (cnt_t != 2'd3) begin
            state <= S_MUL;
          end else if (IW'(k + 1'b1) == hi) begin
            state <= S_WR;
          end else begin
            k     <= IW'(k + 1'b1);
            state <= S_RDL;
          end
        end
        S_WR: begin
          if (int'(lo) + int'(span) + 1 < int'(n_reg)) begin
            lo    <= IW'(lo + 1'b1);
            k     <= IW'(lo + 1'b1);
            state <= S_RDL;
          end else if (int'(span) + 1 < int'(n_reg)) begin
            span  <= IW'(span + 1'b1);
            lo    <= '0;
            k     <= '0;
            state <= S_RDL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_data.max_value <= best_max;
            out_data.error     <= ERR_NONE;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.error == ERR_NONE) || (out_data.max_value == 64'd0)))
    else $error("error result with nonzero value");

  // Loading state is cleared for the whole fill.
  a_fill_clean: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((dcount == '0) && (err == ERR_NONE)))
    else $error("load state not cleared during fill");

  // A split point always lies inside its interval.
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDL) |-> ((k >= lo) && (k < hi) && (int'(hi) < int'(n_reg))))
    else $error("split point outside interval");

  // The fill only runs for two or more digits.
  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (int'(n_reg) >= 2))
    else $error("fill started with fewer than two digits");

endmodule
